// ----- hw/rtl/manchester_frame_receiver_macros.svh -----
// Assertion macros for the Manchester frame receiver.
// Expects clk and arst_n in the scope of each use.
`ifndef MANCHESTER_FRAME_RECEIVER_MACROS_SVH
`define MANCHESTER_FRAME_RECEIVER_MACROS_SVH
`ifndef SYNTHESIS
`define MFR_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("mfr assertion failed");
`define MFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfr assertion failed");
`else
`define MFR_ASSERT(label, expr)
`define MFR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/mfr_pkg.sv -----
// Types, codes and helper functions for the Manchester frame receiver.
// No dependencies; used by mfr_step and manchester_frame_receiver.
package mfr_pkg;

	localparam int CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_HIGH = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_LOW  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MISS_LIM  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN   = 8'd3;

	localparam logic [7:0] MISS_LIMIT_RESET = 8'd16;
	localparam logic [7:0] MAX_LEN_RESET    = 8'd255;

	localparam logic [2:0] MODE_HUNT = 3'd0;
	localparam logic [2:0] MODE_BIND = 3'd1;
	localparam logic [2:0] MODE_LEN  = 3'd2;
	localparam logic [2:0] MODE_DATA = 3'd3;
	localparam logic [2:0] MODE_END  = 3'd4;

	localparam logic [2:0] ST_PENDING  = 3'd0;
	localparam logic [2:0] ST_OK       = 3'd1;
	localparam logic [2:0] ST_PREAMBLE = 3'd2;
	localparam logic [2:0] ST_HEAD     = 3'd3;
	localparam logic [2:0] ST_LENGTH   = 3'd4;
	localparam logic [2:0] ST_CHECKSUM = 3'd5;

	localparam logic [1:0] ROLE_LENGTH  = 2'd0;
	localparam logic [1:0] ROLE_PAYLOAD = 2'd1;
	localparam logic [1:0] ROLE_CRC_HI  = 2'd2;
	localparam logic [1:0] ROLE_CRC_LO  = 2'd3;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef struct packed {
		logic [7:0] head_high;
		logic [7:0] head_low;
		logic [7:0] miss_limit;
		logic [7:0] max_len;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  miss_count;
		logic        half_phase;
		logic [3:0]  upper_nibble;
		logic [7:0]  payload_count;
		logic [7:0]  frame_length;
		logic [15:0] crc_acc;
		logic [7:0]  crc_high_rx;
	} state_t;

	typedef struct packed {
		logic [2:0] status;
		logic       byte_valid;
		logic [7:0] byte_out;
		logic [1:0] byte_role;
	} result_t;

	function automatic logic [3:0] even_bits(input logic [7:0] v);
		return {v[6], v[4], v[2], v[0]};
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic state_t hunt_state(input state_t s);
		state_t r;
		r = '0;
		r.mode = MODE_HUNT;
		r.miss_count = s.miss_count;
		return r;
	endfunction

endpackage

// ----- hw/rtl/mfr_step.sv -----
// Next-state and result logic for one raw byte or restart request.
// Depends on mfr_pkg.
module mfr_step import mfr_pkg::*; (
	input  cfg_t       cfg,
	input  state_t     cur,
	input  logic       restart,
	input  logic [7:0] rx_byte,
	output state_t     nxt,
	output result_t    res
);

	logic [7:0] miss_inc;
	logic [7:0] dec;
	logic       done;
	logic       valid;
	logic [1:0] role;
	logic [2:0] status;

	assign miss_inc = cur.miss_count + 8'd1;

	always_comb begin
		nxt = cur;
		dec = 8'h00;
		done = 1'b0;
		valid = 1'b0;
		role = ROLE_LENGTH;
		status = ST_PENDING;
		if (cur.mode == MODE_LEN || cur.mode == MODE_DATA || cur.mode == MODE_END) begin
			if (!cur.half_phase) begin
				nxt.upper_nibble = even_bits(rx_byte);
				nxt.half_phase = 1'b1;
			end else begin
				nxt.half_phase = 1'b0;
				dec = ~{cur.upper_nibble, even_bits(rx_byte)};
				done = 1'b1;
			end
		end
		if (restart) begin
			nxt = hunt_state(cur);
			nxt.miss_count = 8'h00;
		end else begin
			unique case (cur.mode)
				MODE_HUNT: begin
					if (rx_byte != cfg.head_high) begin
						if (miss_inc > cfg.miss_limit) begin
							nxt.miss_count = 8'h00;
							status = ST_PREAMBLE;
						end else begin
							nxt.miss_count = miss_inc;
						end
					end else begin
						nxt.mode = MODE_BIND;
						nxt.payload_count = 8'h00;
					end
				end
				MODE_BIND: begin
					nxt.miss_count = 8'h00;
					if (rx_byte != cfg.head_low) begin
						status = ST_HEAD;
						nxt = hunt_state(nxt);
					end else begin
						nxt.payload_count = 8'h00;
						nxt.half_phase = 1'b0;
						nxt.mode = MODE_LEN;
					end
				end
				MODE_LEN: begin
					if (done) begin
						if (dec > cfg.max_len) begin
							status = ST_LENGTH;
							dec = 8'h00;
							nxt = hunt_state(nxt);
						end else begin
							nxt.frame_length = dec;
							nxt.crc_acc = crc_byte(16'h0000, dec);
							nxt.mode = MODE_DATA;
							valid = 1'b1;
							role = ROLE_LENGTH;
						end
					end
				end
				MODE_DATA: begin
					if (done) begin
						valid = 1'b1;
						if (cur.payload_count >= cur.frame_length) begin
							nxt.crc_high_rx = dec;
							nxt.mode = MODE_END;
							role = ROLE_CRC_HI;
						end else begin
							nxt.crc_acc = crc_byte(cur.crc_acc, dec);
							nxt.payload_count = cur.payload_count + 8'd1;
							role = ROLE_PAYLOAD;
						end
					end
				end
				MODE_END: begin
					if (done) begin
						valid = 1'b1;
						role = ROLE_CRC_LO;
						status = ({cur.crc_high_rx, dec} == cur.crc_acc) ? ST_OK : ST_CHECKSUM;
						nxt = hunt_state(nxt);
					end
				end
				default: begin
					nxt = hunt_state(cur);
				end
			endcase
		end
	end

	assign res.status     = status;
	assign res.byte_valid = valid;
	assign res.byte_out   = valid ? dec : 8'h00;
	assign res.byte_role  = valid ? role : ROLE_LENGTH;

endmodule

// ----- hw/rtl/manchester_frame_receiver.sv -----
// Manchester frame receiver: head flag hunt, pair decode, length and CRC-16 check.
// Results are registered and shown on the master side in the cycle after acceptance.
// Throughput: one request per cycle while no result is held or m_axis_tready is high; state
// and result registers update on accept, so a new request is taken while the result drains.
// Reset (arst_n low, asynchronous): hunting state, config registers to defaults.
// Depends on mfr_pkg, mfr_step and manchester_frame_receiver_macros.svh.
`include "manchester_frame_receiver_macros.svh"
module manchester_frame_receiver import mfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // rx_byte[7:0]
	input  logic                   s_axis_tuser,   // func[0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata,   // status[2:0], byte_out[10:3], zero[15:11]
	output logic [2:0]             m_axis_tuser,   // byte_valid[0], byte_role[2:1]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]             cfg_data
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    s_accept;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_high <= 8'h00;
			cfg_q.head_low <= 8'h00;
			cfg_q.miss_limit <= MISS_LIMIT_RESET;
			cfg_q.max_len <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HEAD_HIGH: cfg_q.head_high <= cfg_data;
				CFG_HEAD_LOW:  cfg_q.head_low <= cfg_data;
				CFG_MISS_LIM:  cfg_q.miss_limit <= cfg_data;
				CFG_MAX_LEN:   cfg_q.max_len <= cfg_data;
				default: ;
			endcase
		end
	end

	mfr_step u_step (
		.cfg     (cfg_q),
		.cur     (state_q),
		.restart (s_axis_tuser),
		.rx_byte (s_axis_tdata),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			state_q <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, res_q.byte_out, res_q.status};
	assign m_axis_tuser  = {res_q.byte_role, res_q.byte_valid};

	`MFR_ASSERT_NEXT(a_restart_hunt, s_accept && s_axis_tuser,
		state_q.mode == MODE_HUNT && state_q.miss_count == 8'h00)
	`MFR_ASSERT_NEXT(a_status_hunt, s_accept && res.status != ST_PENDING,
		state_q.mode == MODE_HUNT && state_q.crc_acc == 16'h0000)
	`MFR_ASSERT(a_half_clear, (state_q.mode == MODE_HUNT || state_q.mode == MODE_BIND)
		-> !state_q.half_phase)
	`MFR_ASSERT(a_crc_lo_end, (res.byte_valid && res.byte_role == ROLE_CRC_LO)
		-> (res.status == ST_OK || res.status == ST_CHECKSUM))

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for manchester_frame_receiver: drives line bytes and restarts,
// predicts each decoded result and compares it field by field against the master side.
// Depends on mfr_pkg and the manchester_frame_receiver RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mfr_pkg::*;

	typedef struct packed {
		logic       restart;
		logic [7:0] raw;
	} line_item_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = '0;   // rx_byte[7:0]
	logic                   s_axis_tuser = 1'b0; // func[0]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [15:0]            m_axis_tdata;        // status[2:0], byte_out[10:3], zero[15:11]
	logic [2:0]             m_axis_tuser;        // byte_valid[0], byte_role[2:1]
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]             cfg_data = '0;

	line_item_t line_bytes[$];
	result_t    pending_decodes[$];
	logic       in_taken = 1'b0;
	int         send_idle = 24;
	int         recv_idle = 63;
	int         queued_items = 0;
	int         mismatch_count = 0;

	logic [7:0] gen_head_hi = 8'h00;
	logic [7:0] gen_head_lo = 8'h00;
	logic [7:0] gen_miss_lim = MISS_LIMIT_RESET;
	logic [7:0] gen_max_len = MAX_LEN_RESET;

	logic [7:0]  pr_head_hi;
	logic [7:0]  pr_head_lo;
	logic [7:0]  pr_miss_lim;
	logic [7:0]  pr_max_len;
	logic [2:0]  pr_mode;
	logic [7:0]  pr_miss;
	logic        pr_half;
	logic [3:0]  pr_upper;
	logic [7:0]  pr_count;
	logic [7:0]  pr_len;
	logic [15:0] pr_crc;
	logic [7:0]  pr_crc_hi;

	manchester_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
		end
		return c;
	endfunction

	function automatic void frame_return_to_hunt();
		pr_mode = MODE_HUNT;
		pr_half = 1'b0;
		pr_upper = '0;
		pr_count = '0;
		pr_len = '0;
		pr_crc = '0;
		pr_crc_hi = '0;
	endfunction

	function automatic result_t decode_line_byte(input logic restart, input logic [7:0] raw);
		result_t    r;
		logic [7:0] dec;
		r = '0;
		if (restart) begin
			pr_miss = '0;
			frame_return_to_hunt();
		end else begin
			case (pr_mode)
				MODE_HUNT: begin
					if (raw != pr_head_hi) begin
						pr_miss = pr_miss + 8'd1;
						if (pr_miss > pr_miss_lim) begin
							pr_miss = '0;
							r.status = ST_PREAMBLE;
						end
					end else begin
						pr_mode = MODE_BIND;
						pr_count = '0;
					end
				end
				MODE_BIND: begin
					pr_miss = '0;
					if (raw != pr_head_lo) begin
						r.status = ST_HEAD;
						frame_return_to_hunt();
					end else begin
						pr_count = '0;
						pr_half = 1'b0;
						pr_mode = MODE_LEN;
					end
				end
				MODE_LEN, MODE_DATA, MODE_END: begin
					if (!pr_half) begin
						pr_upper = {raw[6], raw[4], raw[2], raw[0]};
						pr_half = 1'b1;
					end else begin
						pr_half = 1'b0;
						dec = ~{pr_upper, raw[6], raw[4], raw[2], raw[0]};
						r.byte_valid = 1'b1;
						r.byte_out = dec;
						if (pr_mode == MODE_LEN) begin
							if (dec > pr_max_len) begin
								r = '0;
								r.status = ST_LENGTH;
								frame_return_to_hunt();
							end else begin
								pr_len = dec;
								pr_crc = crc_ccitt_next(16'h0000, dec);
								pr_mode = MODE_DATA;
								r.byte_role = ROLE_LENGTH;
							end
						end else if (pr_mode == MODE_DATA) begin
							if (pr_count >= pr_len) begin
								pr_crc_hi = dec;
								pr_mode = MODE_END;
								r.byte_role = ROLE_CRC_HI;
							end else begin
								pr_crc = crc_ccitt_next(pr_crc, dec);
								pr_count = pr_count + 8'd1;
								r.byte_role = ROLE_PAYLOAD;
							end
						end else begin
							r.byte_role = ROLE_CRC_LO;
							r.status = ({pr_crc_hi, dec} == pr_crc) ? ST_OK : ST_CHECKSUM;
							frame_return_to_hunt();
						end
					end
				end
				default: frame_return_to_hunt();
			endcase
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
		if (mismatch_count < 100) begin
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		end
		mismatch_count++;
	endtask

	always @(negedge clk) begin
		line_item_t nx;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (line_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				nx = line_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nx.raw;
				s_axis_tuser <= nx.restart;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		in_taken <= s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.byte_out = m_axis_tdata[10:3];
			got.byte_valid = m_axis_tuser[0];
			got.byte_role = m_axis_tuser[2:1];
			if (pending_decodes.size() == 0) begin
				note_mismatch("unexpected result", 16'(got), 16'h0);
			end else begin
				want = pending_decodes.pop_front();
				if (got.status != want.status)
					note_mismatch("status", 16'(got.status), 16'(want.status));
				if (got.byte_valid != want.byte_valid)
					note_mismatch("byte_valid", 16'(got.byte_valid), 16'(want.byte_valid));
				if (got.byte_out != want.byte_out)
					note_mismatch("byte_out", 16'(got.byte_out), 16'(want.byte_out));
				if (got.byte_role != want.byte_role)
					note_mismatch("byte_role", 16'(got.byte_role), 16'(want.byte_role));
			end
		end
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HEAD_HIGH: pr_head_hi = cfg_data;
				CFG_HEAD_LOW:  pr_head_lo = cfg_data;
				CFG_MISS_LIM:  pr_miss_lim = cfg_data;
				CFG_MAX_LEN:   pr_max_len = cfg_data;
				default: ;
			endcase
		end
		if (s_axis_tvalid && s_axis_tready) begin
			pending_decodes.push_back(decode_line_byte(s_axis_tuser, s_axis_tdata));
		end
	end

	task automatic push_raw(input logic [7:0] b);
		line_bytes.push_back('{restart: 1'b0, raw: b});
		queued_items++;
	endtask

	task automatic push_restart();
		line_bytes.push_back('{restart: 1'b1, raw: 8'($urandom)});
		queued_items++;
	endtask

	task automatic push_decoded(input logic [7:0] d);
		logic [7:0] inv;
		logic [7:0] a;
		logic [7:0] b;
		inv = ~d;
		a = 8'($urandom);
		b = 8'($urandom);
		{a[6], a[4], a[2], a[0]} = inv[7:4];
		{b[6], b[4], b[2], b[0]} = inv[3:0];
		push_raw(a);
		push_raw(b);
	endtask

	task automatic push_frame(input logic [7:0] len, input logic bad_crc, input logic fill_extremes);
		logic [15:0] c;
		logic [7:0]  d;
		push_raw(gen_head_hi);
		push_raw(gen_head_lo);
		push_decoded(len);
		c = crc_ccitt_next(16'h0000, len);
		for (int i = 0; i < len; i++) begin
			d = fill_extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
			c = crc_ccitt_next(c, d);
			push_decoded(d);
		end
		if (bad_crc)
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		push_decoded(c[15:8]);
		push_decoded(c[7:0]);
	endtask

	task automatic program_regs(input logic [7:0] hh, input logic [7:0] hl,
			input logic [7:0] ml, input logic [7:0] mx);
		logic [CFG_INDEX_W-1:0] idx[4];
		logic [7:0]             val[4];
		idx = '{CFG_HEAD_HIGH, CFG_HEAD_LOW, CFG_MISS_LIM, CFG_MAX_LEN};
		val = '{hh, hl, ml, mx};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		gen_head_hi = hh;
		gen_head_lo = hl;
		gen_miss_lim = ml;
		gen_max_len = mx;
	endtask

	task automatic drain();
		while (line_bytes.size() != 0 || s_axis_tvalid || pending_decodes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_length();
		if ($urandom_range(0, 49) == 0)
			return gen_max_len;
		return 8'($urandom_range(0, (gen_max_len < 10) ? gen_max_len : 10));
	endfunction

	task automatic add_random_sequence();
		int k;
		int n;
		k = $urandom_range(0, 99);
		if (k < 55) begin
			push_frame(pick_length(), 1'b0, 1'b0);
		end else if (k < 67) begin
			push_frame(pick_length(), 1'b1, 1'b0);
		end else if (k < 74) begin
			if (gen_max_len != 8'hFF) begin
				push_raw(gen_head_hi);
				push_raw(gen_head_lo);
				push_decoded(8'($urandom_range(gen_max_len + 1, 255)));
			end else begin
				push_frame(pick_length(), 1'b0, 1'b0);
			end
		end else if (k < 81) begin
			push_raw(gen_head_hi);
			push_raw(gen_head_lo ^ 8'($urandom_range(1, 255)));
		end else if (k < 90) begin
			n = (gen_miss_lim < 26) ? gen_miss_lim + 4 : 30;
			repeat ($urandom_range(1, n)) push_raw(8'($urandom));
			if ($urandom_range(0, 1))
				push_restart();
		end else begin
			push_raw(gen_head_hi);
			push_raw(gen_head_lo);
			repeat ($urandom_range(1, 6)) push_raw(8'($urandom));
			push_restart();
		end
	endtask

	initial begin
		pr_head_hi = 8'h00;
		pr_head_lo = 8'h00;
		pr_miss_lim = MISS_LIMIT_RESET;
		pr_max_len = MAX_LEN_RESET;
		pr_miss = '0;
		frame_return_to_hunt();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_frame(8'd2, 1'b0, 1'b1);
		push_raw(8'h00);
		push_raw(8'h55);
		push_raw(8'h00);
		push_raw(8'h00);
		push_raw(8'hFF);
		push_restart();
		push_frame(8'd0, 1'b1, 1'b0);
		drain();

		program_regs(8'hFF, 8'hFF, 8'h00, 8'h00);
		push_raw(8'h00);
		push_raw(8'hFF);
		push_raw(8'hFF);
		push_decoded(8'd1);
		push_frame(8'd0, 1'b0, 1'b0);
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p < 2) begin
				send_idle = 24;
				recv_idle = 63;
			end else if (p < 4) begin
				send_idle = 63;
				recv_idle = 24;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (p)
				0: program_regs(8'($urandom), 8'($urandom), 8'hFF, 8'hFF);
				1: program_regs(8'h00, 8'hFF, 8'h00, 8'h00);
				default: program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(0, 40)),
					($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 20)));
			endcase
			queued_items = 0;
			while (queued_items < 250)
				add_random_sequence();
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_decodes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ----- manchester_frame_receiver.f -----
+incdir+hw/rtl
hw/rtl/mfr_pkg.sv
hw/rtl/mfr_step.sv
hw/rtl/manchester_frame_receiver.sv
dv/testbench.sv
